// File: rtl/llprc_pkg.sv
package llprc_pkg;

    localparam int PALETTE_SIZE = 256;
    localparam int PAL_AW       = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
    localparam int DIST_W       = 18;
    localparam logic [8:0] COUNT_MAX = 9'd256;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_CHECK = 1'b1
    } command_t;

    typedef struct packed {
        logic       command;
        logic [7:0] entry_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [4:0] level;
        logic [7:0] expected_index;
        logic       end_of_level;
    } item_beat_t;

    typedef struct packed {
        logic [7:0] nearest_index;
        logic       mismatch;
        logic [8:0] mismatch_total;
        logic       level_done;
    } result_beat_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DARK,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic load_wr;
        logic fetch;
        logic dark_en;
        logic scan_rd;
        logic result_en;
    } ctrl_cmd_t;

    typedef struct packed {
        logic pipe_busy;
        logic scan_last;
        logic out_free;
    } ctrl_sts_t;

endpackage

// File: rtl/light_level_palette_remap_check.sv
// Load beat: written to the palette in the cycle it is accepted; next beat taken next cycle.
// Check beat: the result is set by the palette scan, one distance per cycle from
// the single palette read port.
// Input is taken again once the result sits in the output register; no new beat is
// accepted while a check is in progress.
// Reset (rst_n, async, active low) clears the controller, the output valid and the
// mismatch total; the palette is undefined until loaded.
module light_level_palette_remap_check
    import llprc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         item_valid,
    output logic         item_ready,
    input  item_beat_t   item,
    output logic         result_valid,
    input  logic         result_ready,
    output result_beat_t result
);

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    llprc_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_command (item.command),
        .item_ready   (item_ready),
        .sts          (sts),
        .cmd          (cmd)
    );

    llprc_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .sts          (sts),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

// File: rtl/llprc_ctrl.sv
module llprc_ctrl
    import llprc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    input  logic      item_command,
    output logic      item_ready,
    input  ctrl_sts_t sts,
    output ctrl_cmd_t cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        accept;

    assign accept = item_valid && item_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (item_command == CMD_CHECK))
                begin
                    state_next = S_DARK;
                end
            end
            S_DARK:
            begin
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (sts.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!sts.pipe_busy)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        item_ready    = 1'b0;
        cmd           = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                item_ready  = 1'b1;
                cmd.load_wr = item_valid && (item_command == CMD_LOAD);
                cmd.fetch   = item_valid && (item_command == CMD_CHECK);
            end
            S_DARK:
            begin
                cmd.dark_en = 1'b1;
            end
            S_SCAN:
            begin
                cmd.scan_rd = 1'b1;
            end
            S_DRAIN:
            begin
                cmd = '0;
            end
            S_DONE:
            begin
                cmd.result_en = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// File: rtl/llprc_dp.sv
module llprc_dp
    import llprc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  item_beat_t   item,
    input  ctrl_cmd_t    cmd,
    output ctrl_sts_t    sts,
    output logic         result_valid,
    input  logic         result_ready,
    output result_beat_t result
);

    logic [23:0]       mem [PALETTE_SIZE];
    logic [PAL_AW-1:0] rd_addr;
    logic [23:0]       rd_data_reg;
    logic              in_range;

    logic [4:0]        level_reg;
    logic [7:0]        expected_reg;
    logic              eol_reg;
    logic              black_reg;

    logic [7:0]        dark_r_reg, dark_g_reg, dark_b_reg;
    logic [7:0]        dark_r_next, dark_g_next, dark_b_next;
    logic [23:0]       src_color;
    logic [5:0]        scale;

    logic [PAL_AW-1:0] scan_addr_reg;
    logic              rd_valid_reg;
    logic [PAL_AW-1:0] rd_idx_reg;
    logic              dist_valid_reg;
    logic [PAL_AW-1:0] dist_idx_reg;
    logic [DIST_W-1:0] dist_reg;
    logic [DIST_W-1:0] dist_next;

    logic [DIST_W-1:0] best_d_reg;
    logic [PAL_AW-1:0] best_idx_reg;

    logic [8:0]        count_reg;
    logic [8:0]        total_next;
    logic              miss;
    logic [7:0]        nearest;

    logic              out_valid_reg;
    result_beat_t      out_reg;

    function automatic logic [7:0] darken(input logic [7:0] c, input logic [5:0] s);
        logic [13:0] prod;
        prod = 14'({6'd0, c} * {8'd0, s}) + 14'd16;
        return prod[12:5];
    endfunction

    function automatic logic [15:0] sq_diff(input logic [7:0] a, input logic [7:0] b);
        logic signed [8:0]  d;
        logic signed [17:0] p;
        d = $signed({1'b0, a}) - $signed({1'b0, b});
        p = d * d;
        return p[15:0];
    endfunction

    assign in_range = ({1'b0, item.entry_index} < 9'(PALETTE_SIZE));
    assign rd_addr  = cmd.scan_rd ? scan_addr_reg : item.entry_index[PAL_AW-1:0];

    // palette memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.load_wr && in_range)
        begin
            mem[item.entry_index[PAL_AW-1:0]] <= {item.red, item.green, item.blue};
        end
        rd_data_reg <= mem[rd_addr];
    end

    // capture check fields
    always_ff @(posedge clk)
    begin
        if (cmd.fetch)
        begin
            level_reg    <= item.level;
            expected_reg <= item.expected_index;
            eol_reg      <= item.end_of_level;
            black_reg    <= !in_range;
        end
    end

    assign src_color   = black_reg ? 24'd0 : rd_data_reg;
    assign scale       = 6'd32 - {1'b0, level_reg};
    assign dark_r_next = darken(src_color[23:16], scale);
    assign dark_g_next = darken(src_color[15:8], scale);
    assign dark_b_next = darken(src_color[7:0], scale);

    always_ff @(posedge clk)
    begin
        if (cmd.dark_en)
        begin
            dark_r_reg <= dark_r_next;
            dark_g_reg <= dark_g_next;
            dark_b_reg <= dark_b_next;
        end
    end

    assign dist_next = DIST_W'(sq_diff(rd_data_reg[23:16], dark_r_reg))
                     + DIST_W'(sq_diff(rd_data_reg[15:8], dark_g_reg))
                     + DIST_W'(sq_diff(rd_data_reg[7:0], dark_b_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_addr_reg  <= '0;
            rd_valid_reg   <= 1'b0;
            dist_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.dark_en)
            begin
                scan_addr_reg <= '0;
            end
            else if (cmd.scan_rd)
            begin
                scan_addr_reg <= scan_addr_reg + 1'b1;
            end
            rd_valid_reg   <= cmd.scan_rd;
            dist_valid_reg <= rd_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg   <= scan_addr_reg;
        dist_idx_reg <= rd_idx_reg;
        dist_reg     <= dist_next;
    end

    // keep the lowest index on a tie
    always_ff @(posedge clk)
    begin
        if (cmd.dark_en)
        begin
            best_d_reg   <= '1;
            best_idx_reg <= '0;
        end
        else if (dist_valid_reg && (dist_reg < best_d_reg))
        begin
            best_d_reg   <= dist_reg;
            best_idx_reg <= dist_idx_reg;
        end
    end

    assign nearest    = 8'(best_idx_reg);
    assign miss       = (nearest != expected_reg);
    assign total_next = (miss && (count_reg != COUNT_MAX)) ? count_reg + 9'd1 : count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.result_en)
            begin
                count_reg     <= eol_reg ? 9'd0 : total_next;
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.result_en)
        begin
            out_reg.nearest_index  <= nearest;
            out_reg.mismatch       <= miss;
            out_reg.mismatch_total <= total_next;
            out_reg.level_done     <= eol_reg;
        end
    end

    assign result_valid  = out_valid_reg;
    assign result        = out_reg;

    assign sts.pipe_busy = rd_valid_reg || dist_valid_reg;
    assign sts.scan_last = (scan_addr_reg == PAL_AW'(PALETTE_SIZE - 1));
    assign sts.out_free  = !out_valid_reg || result_ready;

endmodule
